// ===== rtl/core/drp_pkg.sv =====
`default_nettype none
package drp_pkg;

  // Packet length limit and position counter width (holds MAX_LEN + 1)
  localparam int MAX_LEN = 1024;
  localparam int POS_W   = $clog2(MAX_LEN + 2);

  // Fixed header layout
  localparam int HDR_END    = 3;
  localparam int XID_LO     = 4;
  localparam int XID_HI     = 8;
  localparam int OFFER_LO   = 16;
  localparam int OFFER_HI   = 20;
  localparam int MAC_LO     = 28;
  localparam int MAC_HI     = 34;
  localparam int COOKIE_LO  = 236;
  localparam int OPT_LO     = 240;
  localparam int MIN_LEN    = 240;

  // Option codes
  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_END      = 8'd255;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;

  // Result error codes
  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_LENGTH   = 3'd1;
  localparam logic [2:0] ERR_HEADER   = 3'd2;
  localparam logic [2:0] ERR_COOKIE   = 3'd3;
  localparam logic [2:0] ERR_NO_TYPE  = 3'd4;

  // Register indexes
  localparam logic REG_WANTED_CODE = 1'b0;
  localparam logic REG_CLIENT_MAC  = 1'b1;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // What the front decided about one byte
  typedef enum logic [2:0] {
    K_OTHER,
    K_HDR,
    K_XID,
    K_OFFER,
    K_MAC,
    K_COOKIE,
    K_OPT,
    K_SKIP
  } drp_kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last;
    logic       len_bad;
    drp_kind_t  kind;
    logic [2:0] idx;
  } drp_entry_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  error_code;
    logic [2:0]  msg_type;
    logic [31:0] transaction_id;
    logic [31:0] your_address;
    logic        for_us;
    logic        opt_found;
    logic [7:0]  opt_length;
    logic [31:0] opt_value;
  } drp_result_t;

  // Expected op, htype, hlen
  function automatic logic [7:0] hdr_expect(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'd2;
      3'd1:    v = 8'd1;
      3'd2:    v = 8'd6;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // Magic cookie bytes
  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'd99;
      2'd1:    v = 8'd130;
      2'd2:    v = 8'd83;
      default: v = 8'd99;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/drp_in_if.sv =====
`default_nettype none
interface drp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last;

  modport source (output valid, output rx_byte, output last, input ready);
  modport sink   (input valid, input rx_byte, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/drp_out_if.sv =====
`default_nettype none
interface drp_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [2:0]  error_code;
  logic [2:0]  msg_type;
  logic [31:0] transaction_id;
  logic [31:0] your_address;
  logic        for_us;
  logic        opt_found;
  logic [7:0]  opt_length;
  logic [31:0] opt_value;

  modport source (output valid, output accepted, output error_code, output msg_type,
                  output transaction_id, output your_address, output for_us,
                  output opt_found, output opt_length, output opt_value, input ready);
  modport sink   (input valid, input accepted, input error_code, input msg_type,
                  input transaction_id, input your_address, input for_us,
                  input opt_found, input opt_length, input opt_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/drp_fifo.sv =====
`default_nettype none
module drp_fifo (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  drp_pkg::drp_entry_t push_data,
  output logic                full,
  input  wire                 pop,
  output drp_pkg::drp_entry_t pop_data,
  output logic                not_empty
);
  import drp_pkg::*;

  drp_entry_t        mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;
  logic               do_push, do_pop;

  assign full      = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  // Store items
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/drp_front.sv =====
`default_nettype none
module drp_front (
  input  wire                 clk,
  input  wire                 rst_n,
  drp_in_if.sink              in_ch,
  input  wire                 q_full,
  output logic                q_push,
  output drp_pkg::drp_entry_t q_data
);
  import drp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] pos_after;
  logic [POS_W-1:0] mac_off, cookie_off;
  logic             take;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && in_ch.ready;

  assign take       = (pos_r < POS_W'(MAX_LEN));
  assign pos_after  = (pos_r <= POS_W'(MAX_LEN)) ? pos_r + 1'b1 : pos_r;
  assign mac_off    = pos_r - POS_W'(MAC_LO);
  assign cookie_off = pos_r - POS_W'(COOKIE_LO);

  // Classify the byte by its position in the packet
  always_comb begin
    q_data.rx_byte = in_ch.rx_byte;
    q_data.last    = in_ch.last;
    q_data.len_bad = (pos_after < POS_W'(MIN_LEN)) || (pos_after > POS_W'(MAX_LEN));
    q_data.kind    = K_OTHER;
    q_data.idx     = '0;
    if (!take) begin
      q_data.kind = K_SKIP;
    end else if (pos_r < POS_W'(HDR_END)) begin
      q_data.kind = K_HDR;
      q_data.idx  = pos_r[2:0];
    end else if (pos_r >= POS_W'(XID_LO) && pos_r < POS_W'(XID_HI)) begin
      q_data.kind = K_XID;
    end else if (pos_r >= POS_W'(OFFER_LO) && pos_r < POS_W'(OFFER_HI)) begin
      q_data.kind = K_OFFER;
    end else if (pos_r >= POS_W'(MAC_LO) && pos_r < POS_W'(MAC_HI)) begin
      q_data.kind = K_MAC;
      q_data.idx  = mac_off[2:0];
    end else if (pos_r >= POS_W'(COOKIE_LO) && pos_r < POS_W'(OPT_LO)) begin
      q_data.kind = K_COOKIE;
      q_data.idx  = cookie_off[2:0];
    end else if (pos_r >= POS_W'(OPT_LO)) begin
      q_data.kind = K_OPT;
    end
  end

  // Count bytes, restart after the last one
  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      pos_nxt = in_ch.last ? '0 : pos_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/drp_back.sv =====
`default_nettype none
module drp_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_valid,
  input  drp_pkg::drp_entry_t q_data,
  output logic                q_pop,
  input  wire  [7:0]          wanted_code,
  input  wire  [47:0]         client_mac,
  drp_out_if.source           out_ch
);
  import drp_pkg::*;

  typedef enum logic [1:0] {PH_CODE, PH_LEN, PH_VALUE} phase_t;
  typedef enum logic [1:0] {ST_NONE, ST_PENDING, ST_DONE} track_t;

  phase_t      phase_r, phase_nxt;
  track_t      type_st_r, type_st_nxt, want_st_r, want_st_nxt;
  logic        hdr_ok_r, hdr_ok_nxt, cookie_ok_r, cookie_ok_nxt;
  logic        mac_eq_r, mac_eq_nxt, stopped_r, stopped_nxt;
  logic [31:0] xid_r, xid_nxt, offer_r, offer_nxt, want_val_r, want_val_nxt;
  logic [7:0]  code_r, code_nxt, left_r, left_nxt;
  logic [7:0]  type_len_r, type_len_nxt, type_val_r, type_val_nxt;
  logic [7:0]  want_len_r, want_len_nxt;
  logic        out_valid_r;
  drp_result_t res_r, res_nxt;
  logic        type_valid, load;
  logic [7:0]  left_dec, val_idx;
  logic [7:0]  b;

  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = mac[47:40];
      3'd1:    v = mac[39:32];
      3'd2:    v = mac[31:24];
      3'd3:    v = mac[23:16];
      3'd4:    v = mac[15:8];
      default: v = mac[7:0];
    endcase
    return v;
  endfunction

  // Take an item unless it is the last one and the result slot is busy
  assign q_pop = q_valid && (!q_data.last || !out_valid_r || out_ch.ready);
  assign load  = q_pop && q_data.last;
  assign b     = q_data.rx_byte;

  assign left_dec = left_r - 8'd1;
  assign val_idx  = want_len_r - left_r;

  // Update packet state for one byte
  always_comb begin
    phase_nxt     = phase_r;
    type_st_nxt   = type_st_r;
    want_st_nxt   = want_st_r;
    hdr_ok_nxt    = hdr_ok_r;
    cookie_ok_nxt = cookie_ok_r;
    mac_eq_nxt    = mac_eq_r;
    stopped_nxt   = stopped_r;
    xid_nxt       = xid_r;
    offer_nxt     = offer_r;
    want_val_nxt  = want_val_r;
    code_nxt      = code_r;
    left_nxt      = left_r;
    type_len_nxt  = type_len_r;
    type_val_nxt  = type_val_r;
    want_len_nxt  = want_len_r;
    if (q_pop) begin
      case (q_data.kind)
        K_HDR: begin
          if (b != hdr_expect(q_data.idx)) hdr_ok_nxt = 1'b0;
        end
        K_XID:   xid_nxt   = {xid_r[23:0], b};
        K_OFFER: offer_nxt = {offer_r[23:0], b};
        K_MAC: begin
          if (b != mac_byte(client_mac, q_data.idx)) mac_eq_nxt = 1'b0;
        end
        K_COOKIE: begin
          if (b != cookie_byte(q_data.idx[1:0])) cookie_ok_nxt = 1'b0;
        end
        K_OPT: begin
          if (!stopped_r) begin
            unique case (phase_r)
              PH_CODE: begin
                if (b == OPT_END) begin
                  stopped_nxt = 1'b1;
                end else if (b != OPT_PAD) begin
                  code_nxt = b;
                  if (b == OPT_MSG_TYPE && type_st_r == ST_NONE) type_st_nxt = ST_PENDING;
                  if (b == wanted_code && want_st_r == ST_NONE) want_st_nxt = ST_PENDING;
                  phase_nxt = PH_LEN;
                end
              end
              PH_LEN: begin
                left_nxt = b;
                if (type_st_r == ST_PENDING) type_len_nxt = b;
                if (want_st_r == ST_PENDING) want_len_nxt = b;
                if (b == 8'd0) begin
                  if (type_st_r == ST_PENDING) type_st_nxt = ST_DONE;
                  if (want_st_r == ST_PENDING) want_st_nxt = ST_DONE;
                  phase_nxt = PH_CODE;
                end else begin
                  phase_nxt = PH_VALUE;
                end
              end
              PH_VALUE: begin
                if (type_st_r == ST_PENDING && left_r == type_len_r) type_val_nxt = b;
                if (want_st_r == ST_PENDING && val_idx < 8'd4) begin
                  case (val_idx[1:0])
                    2'd0:    want_val_nxt[31:24] = want_val_r[31:24] | b;
                    2'd1:    want_val_nxt[23:16] = want_val_r[23:16] | b;
                    2'd2:    want_val_nxt[15:8]  = want_val_r[15:8] | b;
                    default: want_val_nxt[7:0]   = want_val_r[7:0] | b;
                  endcase
                end
                left_nxt = left_dec;
                if (left_dec == 8'd0) begin
                  if (type_st_r == ST_PENDING) type_st_nxt = ST_DONE;
                  if (want_st_r == ST_PENDING) want_st_nxt = ST_DONE;
                  phase_nxt = PH_CODE;
                end
              end
              default: phase_nxt = PH_CODE;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Build the report from the state after this byte
  always_comb begin
    type_valid = (type_st_nxt == ST_DONE) && (type_len_nxt == 8'd1) &&
                 (type_val_nxt >= 8'd1) && (type_val_nxt <= 8'd7);
    res_nxt = '0;
    if (q_data.len_bad) begin
      res_nxt.error_code = ERR_LENGTH;
    end else if (!hdr_ok_nxt) begin
      res_nxt.error_code = ERR_HEADER;
    end else if (!cookie_ok_nxt) begin
      res_nxt.error_code = ERR_COOKIE;
    end else begin
      res_nxt.error_code     = type_valid ? ERR_OK : ERR_NO_TYPE;
      res_nxt.msg_type       = type_valid ? type_val_nxt[2:0] : 3'd0;
      res_nxt.transaction_id = xid_nxt;
      res_nxt.your_address   = offer_nxt;
      res_nxt.for_us         = mac_eq_nxt;
      if (want_st_nxt == ST_DONE) begin
        res_nxt.opt_found  = 1'b1;
        res_nxt.opt_length = want_len_nxt;
        res_nxt.opt_value  = want_val_nxt;
      end
    end
    res_nxt.accepted = (res_nxt.error_code == ERR_OK);
  end

  // Hold packet state, clear it after the last byte; hold the report until taken
  always_ff @(posedge clk) begin
    if (!rst_n || load) begin
      phase_r     <= PH_CODE;
      type_st_r   <= ST_NONE;
      want_st_r   <= ST_NONE;
      hdr_ok_r    <= 1'b1;
      cookie_ok_r <= 1'b1;
      mac_eq_r    <= 1'b1;
      stopped_r   <= 1'b0;
      xid_r       <= '0;
      offer_r     <= '0;
      want_val_r  <= '0;
      code_r      <= '0;
      left_r      <= '0;
      type_len_r  <= '0;
      type_val_r  <= '0;
      want_len_r  <= '0;
    end else begin
      phase_r     <= phase_nxt;
      type_st_r   <= type_st_nxt;
      want_st_r   <= want_st_nxt;
      hdr_ok_r    <= hdr_ok_nxt;
      cookie_ok_r <= cookie_ok_nxt;
      mac_eq_r    <= mac_eq_nxt;
      stopped_r   <= stopped_nxt;
      xid_r       <= xid_nxt;
      offer_r     <= offer_nxt;
      want_val_r  <= want_val_nxt;
      code_r      <= code_nxt;
      left_r      <= left_nxt;
      type_len_r  <= type_len_nxt;
      type_val_r  <= type_val_nxt;
      want_len_r  <= want_len_nxt;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      res_r       <= res_nxt;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = res_r.accepted;
  assign out_ch.error_code     = res_r.error_code;
  assign out_ch.msg_type       = res_r.msg_type;
  assign out_ch.transaction_id = res_r.transaction_id;
  assign out_ch.your_address   = res_r.your_address;
  assign out_ch.for_us         = res_r.for_us;
  assign out_ch.opt_found      = res_r.opt_found;
  assign out_ch.opt_length     = res_r.opt_length;
  assign out_ch.opt_value      = res_r.opt_value;
endmodule
`default_nettype wire

// ===== rtl/core/dhcp_reply_parser.sv =====
`default_nettype none
// DHCP reply parser. Packet bytes enter on in_ch one per item, the final byte
// marked by last; one report leaves on out_ch for each packet. The block takes
// one byte per clock while the queue has room: a front stage tags each byte by
// its position, a four-item queue decouples it from the back stage, which
// updates the header checks, captures and option walk as it pops each byte.
// The last byte passes through the queue to the back stage, which registers
// the report in an output register and holds it there, so the next packet
// streams in while it waits; a second last byte waits in the queue until that
// register is free. Registers live at cfg_paddr 0 (wanted_code) and 8
// (client_mac); write them between packets.
module dhcp_reply_parser (
  input  wire         clk,
  input  wire         rst_n,
  drp_in_if.sink      in_ch,
  drp_out_if.source   out_ch,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import drp_pkg::*;

  logic [7:0]  wanted_code_r;
  logic [47:0] client_mac_r;
  logic        cfg_wr;
  logic        q_push, q_full, q_pop, q_valid;
  drp_entry_t  q_in, q_out;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_code_r <= 8'd1;
      client_mac_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3])
        REG_WANTED_CODE: wanted_code_r <= cfg_pwdata[7:0];
        REG_CLIENT_MAC:  client_mac_r  <= cfg_pwdata[47:0];
        default: ;
      endcase
    end
  end

  assign cfg_prdata = (cfg_paddr[3] == REG_CLIENT_MAC) ? {16'd0, client_mac_r}
                                                       : {56'd0, wanted_code_r};

  drp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  drp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_valid)
  );

  drp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .wanted_code (wanted_code_r),
    .client_mac  (client_mac_r),
    .out_ch      (out_ch)
  );
endmodule
`default_nettype wire
